// File: sv/msrg_pkg.sv
// ----------------------------------------------------------------------------
// msrg_pkg
// Shared types, constants and helpers of the multimode shell random generator.
// ----------------------------------------------------------------------------
package msrg_pkg;

  localparam int MAX_RETRIES = 16;
  localparam int TRY_W       = (MAX_RETRIES > 2) ? $clog2(MAX_RETRIES) : 1;

  localparam int STATE_W   = 64;
  localparam int VALUE_W   = 15;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = STATE_W / DIV_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [30:0] LCG_MUL   = 31'd1103515245;
  localparam logic [13:0] LCG_INC   = 14'd12345;
  localparam logic [16:0] PM_Q      = 17'd127773;
  localparam logic [14:0] PM_A      = 15'd16807;
  localparam logic [11:0] PM_R      = 12'd2836;
  localparam logic [26:0] ZERO_SUB  = 27'd123459876;
  localparam logic [31:0] NEG_FIX   = 32'h7fff_ffff;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_RETRY = 2'd2;

  typedef enum logic [2:0] {
    MODE_LCG,
    MODE_HALT64,
    MODE_WRAP64,
    MODE_WRAP32,
    MODE_FIX32,
    MODE_FOLD
  } gen_mode_t;

  typedef struct packed {
    logic       seed_load;
    logic       try_load;
    logic       div_step;
    logic       mul;
    logic       upd;
    logic       emit;
    logic [1:0] emit_status;
  } msrg_cmd_t;

  typedef struct packed {
    gen_mode_t mode;
    logic      state_zero;
    logic      value_new;
    logic      out_free;
  } msrg_stat_t;

  function automatic gen_mode_t decode_mode(input logic [2:0] code);
    gen_mode_t m;
    case (code)
      3'd0:    m = MODE_LCG;
      3'd1:    m = MODE_HALT64;
      3'd2:    m = MODE_WRAP64;
      3'd3:    m = MODE_WRAP32;
      3'd4:    m = MODE_FIX32;
      default: m = MODE_FOLD;
    endcase
    return m;
  endfunction

endpackage

// File: sv/msrg_ctrl.sv
// ----------------------------------------------------------------------------
// msrg_ctrl
// Sequencer for seed loads, generator tries, retries and result delivery.
// ----------------------------------------------------------------------------
module msrg_ctrl
  import msrg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_cmd,
  output logic       in_tready,
  input  msrg_stat_t stat,
  output msrg_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRY,
    S_DIV,
    S_MUL,
    S_UPD,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [TRY_W-1:0]   tries_r, tries_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         fin_status_r, fin_status_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    tries_nxt      = tries_r;
    cnt_nxt        = cnt_r;
    fin_status_nxt = fin_status_r;
    cmd            = '0;
    cmd.emit_status = fin_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_cmd == CMD_SEED) begin
            cmd.seed_load = 1'b1;
          end else begin
            tries_nxt = '0;
            state_nxt = S_TRY;
          end
        end
      end
      S_TRY: begin
        if (stat.mode == MODE_HALT64 && stat.state_zero) begin
          fin_status_nxt = ST_HALT;
          state_nxt      = S_FIN;
        end else if (stat.mode == MODE_LCG) begin
          state_nxt = S_MUL;
        end else begin
          cmd.try_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (stat.value_new) begin
          fin_status_nxt = ST_OK;
          state_nxt      = S_FIN;
        end else if (tries_r == TRY_W'(MAX_RETRIES - 1)) begin
          fin_status_nxt = ST_RETRY;
          state_nxt      = S_FIN;
        end else begin
          tries_nxt = tries_r + 1'b1;
          state_nxt = S_TRY;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tries_r      <= '0;
      cnt_r        <= '0;
      fin_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      tries_r      <= tries_nxt;
      cnt_r        <= cnt_nxt;
      fin_status_r <= fin_status_nxt;
    end
  end

endmodule

// File: sv/msrg_dp.sv
// ----------------------------------------------------------------------------
// msrg_dp
// Generator state, constant divider, multipliers, update logic and output
// register of the multimode shell random generator.
// ----------------------------------------------------------------------------
module msrg_dp
  import msrg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_wdata,
  input  logic [STATE_W-1:0] in_seed,
  input  msrg_cmd_t          cmd,
  output msrg_stat_t         stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_value,
  output logic [1:0]         out_status
);

  logic [2:0]         mode_code_r;
  logic [STATE_W-1:0] state_r;
  logic [VALUE_W-1:0] last_r;
  logic [VALUE_W-1:0] cand_r;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [1:0]         out_status_r;

  logic [STATE_W-1:0] dvd_r, dvd_nxt;
  logic [STATE_W-1:0] quo_r, quo_nxt;
  logic [16:0]        rem_r, rem_nxt;
  logic [STATE_W-1:0] pa_r, pb_r;

  gen_mode_t          mode;
  logic [STATE_W-1:0] operand;
  logic [62:0]        prod_lo;
  logic [31:0]        prod_hi;
  logic [31:0]        prod_a;
  logic [59:0]        prod_r;
  logic [STATE_W-1:0] diff;
  logic [31:0]        d32;
  logic [STATE_W-1:0] new_state;
  logic [VALUE_W-1:0] new_value;
  logic [15:0]        fold;

  assign mode = decode_mode(mode_code_r);

  assign stat.mode       = mode;
  assign stat.state_zero = (state_r == '0);
  assign stat.value_new  = (new_value != last_r);
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // Dividend of one try, with the zero state replaced where the variant asks.
  always_comb begin
    case (mode)
      MODE_HALT64: operand = state_r;
      MODE_WRAP64: operand = (state_r == '0) ? STATE_W'(ZERO_SUB) : state_r;
      default: begin
        operand = (state_r[31:0] == '0) ? STATE_W'(ZERO_SUB) : {32'b0, state_r[31:0]};
      end
    endcase
  end

  // Restoring division by the Schrage modulus quotient, four bits a cycle.
  always_comb begin
    logic [16:0]        rem;
    logic [STATE_W-1:0] dvd;
    logic [STATE_W-1:0] quo;
    logic [17:0]        trial;
    rem = rem_r;
    dvd = dvd_r;
    quo = quo_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem, dvd[STATE_W-1]};
      dvd   = {dvd[STATE_W-2:0], 1'b0};
      if (trial >= 18'(PM_Q)) begin
        rem = 17'(trial - 18'(PM_Q));
        quo = {quo[STATE_W-2:0], 1'b1};
      end else begin
        rem = trial[16:0];
        quo = {quo[STATE_W-2:0], 1'b0};
      end
    end
    rem_nxt = rem;
    dvd_nxt = dvd;
    quo_nxt = quo;
  end

  assign prod_lo = 63'(state_r[31:0]) * 63'(LCG_MUL);
  assign prod_hi = state_r[63:32] * 32'(LCG_MUL);
  assign prod_a  = 32'(rem_r) * 32'(PM_A);
  assign prod_r  = 60'(quo_r[47:0]) * 60'(PM_R);

  always_comb begin
    diff = pa_r - pb_r;
    d32  = diff[31:0];
    if (d32[31]) begin
      d32 = d32 + NEG_FIX;
    end
    case (mode)
      MODE_LCG:    new_state = pa_r + pb_r + STATE_W'(LCG_INC);
      MODE_HALT64: new_state = diff;
      MODE_WRAP64: new_state = diff;
      MODE_WRAP32: new_state = {32'b0, diff[31:0]};
      default:     new_state = {32'b0, d32};
    endcase
    fold = new_state[31:16] ^ new_state[15:0];
    case (mode)
      MODE_LCG:  new_value = new_state[30:16];
      MODE_FOLD: new_value = fold[14:0];
      default:   new_value = new_state[14:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_code_r <= 3'd5;
      state_r     <= STATE_W'(1);
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        mode_code_r <= cfg_wdata;
      end
      if (cmd.seed_load) begin
        state_r <= in_seed;
        last_r  <= '0;
      end else if (cmd.upd) begin
        state_r <= new_state;
        if (new_value != last_r) begin
          last_r <= new_value;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.try_load) begin
      dvd_r <= operand;
      quo_r <= '0;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.mul) begin
      if (mode == MODE_LCG) begin
        pa_r <= {1'b0, prod_lo};
        pb_r <= {prod_hi, 32'b0};
      end else begin
        pa_r <= {32'b0, prod_a};
        pb_r <= {4'b0, prod_r};
      end
    end
    if (cmd.upd) begin
      cand_r <= new_value;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_value_r  <= (cmd.emit_status == ST_OK) ? cand_r : '0;
    end
  end

endmodule

// File: sv/multimode_shell_random_generator_top.sv
// ----------------------------------------------------------------------------
// multimode_shell_random_generator_top
// Fifteen-bit pseudo-random source with six selectable generator variants.
// ----------------------------------------------------------------------------
// The input stream carries requests: in_tuser selects a draw (0) or a seed
// load (1), and in_tdata holds the 64-bit seed. A seed load gives no result.
// A draw gives one result on the output stream: out_tdata holds the value
// and out_tuser the status (0 ok, 1 zero state halt, 2 retry bound reached).
// The variant is chosen by cfg_wdata, written when cfg_wen is high while the
// block is idle; this binds the user, the block itself does not enforce it.
// In the Schrage variants a generator try runs the constant divider, which
// retires four quotient bits of the 64-bit state per cycle, then the multiply
// and update steps; in the LCG variant a try runs only the multiply and
// update steps. A draw makes up to 16 tries.
// The block takes one request at a time; in_tready is high only when idle.
// When the receiver stalls, the result waits in the output register and a
// finished draw holds until that register is free.
// Reset sets the variant to the folded one, the state to one and the last
// value to zero.
// ----------------------------------------------------------------------------
module multimode_shell_random_generator_top
  import msrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // seed[63:0]
  input  logic [0:0]  in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // value[14:0], zero[15]
  output logic [1:0]  out_tuser   // status[1:0]
);

  msrg_cmd_t          ctl_cmd;
  msrg_stat_t         dp_stat;
  logic [VALUE_W-1:0] out_value;

  msrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser[0]),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  msrg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_seed    (in_tdata),
    .cmd        (ctl_cmd),
    .stat       (dp_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_status (out_tuser)
  );

  assign out_tdata = {1'b0, out_value};

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.emit |-> (!out_tvalid || out_tready))
    else $error("Result loaded while the output register was still full.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_HALT || out_tuser == ST_RETRY))
    else $error("Result carries an undefined status code.");

  a_fail_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("Failed draw delivered a nonzero value.");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == CMD_DRAW) |=> !in_tready)
    else $error("Block stayed ready after accepting a draw request.");
`endif

endmodule
